FILE: hdl/stti_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stti_pkg
// Field widths, operation and status codes shared by the sorted time table search core.
// ----------------------------------------------------------------------------
package stti_pkg;

    localparam int TIME_W  = 48;
    localparam int VALUE_W = 64;
    localparam int ROWIN_W = 10;
    localparam int COLIN_W = 4;
    localparam int NCOL_W  = 5;

    typedef enum logic [2:0] {
        OP_CLEAR     = 3'd0,
        OP_APPEND    = 3'd1,
        OP_SET       = 3'd2,
        OP_READ      = 3'd3,
        OP_REMOVE    = 3'd4,
        OP_FIND_CUR  = 3'd5,
        OP_FIND_FROM = 3'd6,
        OP_RST_CUR   = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_LATER = 3'd1,
        ST_BAD_INDEX = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

endpackage

FILE: hdl/sorted_time_table_interval_search_core.sv
`timescale 1ns / 1ps
// Append writes all CS columns of a new row (CS = MAX_COLUMNS rounded up to a power of two);
// remove moves every later row up one place, column by column; find first checks the table
// range, then scans intervals from the start row and restarts once from row 0.
// Throughput: one transaction at a time, set by the one read and one write port of each memory and the walks.
// Reset: synchronous, active low; row count, cursor, controls clear, num_columns = 1, memories kept.
// ----------------------------------------------------------------------------
// sorted_time_table_interval_search_core
// Time-sorted row table in block memories with append, edit, remove and a
// cursor-hinted interval search.
// ----------------------------------------------------------------------------
module sorted_time_table_interval_search_core #(
    parameter int MAX_ROWS    = 1024,
    parameter int MAX_COLUMNS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [stti_pkg::NCOL_W-1:0]       i_cfg_wdata,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [2:0]                        i_operation,
    input  logic [stti_pkg::TIME_W-1:0]       i_timestamp,
    input  logic [stti_pkg::ROWIN_W-1:0]      i_row_index,
    input  logic [stti_pkg::COLIN_W-1:0]      i_column,
    input  logic [stti_pkg::VALUE_W-1:0]      i_data_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [2:0]                        o_status,
    output logic [stti_pkg::ROWIN_W-1:0]      o_found_row,
    output logic [stti_pkg::TIME_W-1:0]       o_time_out,
    output logic [stti_pkg::VALUE_W-1:0]      o_value_out
);

    localparam int RW   = $clog2(MAX_ROWS);
    localparam int RCW  = $clog2(MAX_ROWS + 1);
    localparam int CW   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int CS   = 1 << CW;
    localparam int VAW  = RW + CW;
    localparam int XW   = (RCW + 1 > 10) ? RCW + 1 : 10;
    localparam logic [6:0] MAXC = 7'(MAX_COLUMNS);

    typedef enum logic [10:0] {
        S_IDLE      = 11'b000_0000_0001,
        S_EXEC      = 11'b000_0000_0010,
        S_APP_CHK   = 11'b000_0000_0100,
        S_APP_WR    = 11'b000_0000_1000,
        S_RD_WAIT   = 11'b000_0001_0000,
        S_RM_RD     = 11'b000_0010_0000,
        S_RM_WR     = 11'b000_0100_0000,
        S_FIND_T0   = 11'b000_1000_0000,
        S_FIND_TN   = 11'b001_0000_0000,
        S_FIND_PREV = 11'b010_0000_0000,
        S_FIND_CMP  = 11'b100_0000_0000
    } t_state;

    // S_DONE is folded into a flag so the state stays one-hot over work states
    t_state                        r_state, n_state;
    logic                          r_done, n_done;
    stti_pkg::t_op                 r_op;
    logic [stti_pkg::TIME_W-1:0]   r_ts;
    logic [stti_pkg::ROWIN_W-1:0]  r_row;
    logic [stti_pkg::COLIN_W-1:0]  r_col;
    logic [stti_pkg::VALUE_W-1:0]  r_dv;
    logic [RCW-1:0]                r_count, n_count;
    logic [9:0]                    r_cursor, n_cursor;
    logic [stti_pkg::NCOL_W-1:0]   r_ncol;
    logic [RW-1:0]                 r_idx, n_idx;
    logic [CW-1:0]                 r_c, n_c;
    logic [stti_pkg::TIME_W-1:0]   r_prev, n_prev;
    logic                          r_second, n_second;
    stti_pkg::t_status             r_status, n_status;
    logic [9:0]                    r_found, n_found;
    logic [stti_pkg::TIME_W-1:0]   r_tout, n_tout;
    logic [stti_pkg::VALUE_W-1:0]  r_vout, n_vout;
    logic                          r_out_valid;
    stti_pkg::t_status             r_o_status;
    logic [9:0]                    r_o_found;
    logic [stti_pkg::TIME_W-1:0]   r_o_tout;
    logic [stti_pkg::VALUE_W-1:0]  r_o_vout;

    logic [stti_pkg::TIME_W-1:0]   time_mem [MAX_ROWS];
    logic [stti_pkg::VALUE_W-1:0]  value_mem [MAX_ROWS * CS];
    logic [stti_pkg::TIME_W-1:0]   r_t_rdata;
    logic [stti_pkg::VALUE_W-1:0]  r_v_rdata;
    logic [RW-1:0]                 t_raddr, t_waddr;
    logic                          t_we;
    logic [stti_pkg::TIME_W-1:0]   t_wdata;
    logic [VAW-1:0]                v_raddr, v_waddr;
    logic                          v_we;
    logic [stti_pkg::VALUE_W-1:0]  v_wdata;

    logic                          in_acc;
    logic                          out_load;
    logic [6:0]                    ncol7, cols;
    logic [XW-1:0]                 row_x, count_x, idx_x, start_x;
    logic [RW-1:0]                 row_a, cnt_a, start_a;
    logic [CW-1:0]                 col_a;
    logic                          bad_row, bad_col;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_load = r_done && (!r_out_valid || !i_out_stall);
    assign o_in_stall = (r_state != S_IDLE) || r_done;

    assign ncol7 = {2'b00, r_ncol};
    assign cols  = (ncol7 == 7'd0) ? 7'd1 : ((ncol7 > MAXC) ? MAXC : ncol7);

    assign row_x   = XW'(r_row);
    assign count_x = XW'(r_count);
    assign idx_x   = XW'(r_idx);
    assign start_x = (r_op == stti_pkg::OP_FIND_CUR) ? XW'(r_cursor) : row_x;
    assign row_a   = RW'(r_row);
    assign start_a = RW'(start_x);
    assign cnt_a   = RW'(r_count);
    assign col_a   = CW'(r_col);
    assign bad_row = row_x >= count_x;
    assign bad_col = {3'b000, r_col} >= cols;

    always_ff @(posedge i_clk) begin
        if (t_we) begin
            time_mem[t_waddr] <= t_wdata;
        end
        r_t_rdata <= time_mem[t_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (v_we) begin
            value_mem[v_waddr] <= v_wdata;
        end
        r_v_rdata <= value_mem[v_raddr];
    end

    always_comb begin
        n_state  = r_state;
        n_done   = r_done;
        n_count  = r_count;
        n_cursor = r_cursor;
        n_idx    = r_idx;
        n_c      = r_c;
        n_prev   = r_prev;
        n_second = r_second;
        n_status = r_status;
        n_found  = r_found;
        n_tout   = r_tout;
        n_vout   = r_vout;
        t_raddr  = '0;
        t_we     = 1'b0;
        t_waddr  = cnt_a;
        t_wdata  = r_ts;
        v_raddr  = '0;
        v_we     = 1'b0;
        v_waddr  = {cnt_a, r_c};
        v_wdata  = r_dv;

        case (r_state)
            S_IDLE: begin
                if (out_load) begin
                    n_done = 1'b0;
                end
                if (in_acc) begin
                    n_state  = S_EXEC;
                    n_status = stti_pkg::ST_OK;
                    n_found  = '0;
                    n_tout   = '0;
                    n_vout   = '0;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                case (r_op)
                    stti_pkg::OP_CLEAR: begin
                        n_count = '0;
                    end
                    stti_pkg::OP_APPEND: begin
                        n_c = '0;
                        if (count_x >= XW'(MAX_ROWS)) begin
                            n_status = stti_pkg::ST_FULL;
                        end else if (r_count == '0) begin
                            n_state = S_APP_WR;
                            n_done  = 1'b0;
                        end else begin
                            t_raddr = RW'(count_x - 1'b1);
                            n_state = S_APP_CHK;
                            n_done  = 1'b0;
                        end
                    end
                    stti_pkg::OP_SET, stti_pkg::OP_READ: begin
                        if (bad_row || bad_col) begin
                            n_status = stti_pkg::ST_BAD_INDEX;
                        end else if (r_op == stti_pkg::OP_SET) begin
                            v_we    = 1'b1;
                            v_waddr = {row_a, col_a};
                        end else begin
                            t_raddr = row_a;
                            v_raddr = {row_a, col_a};
                            n_state = S_RD_WAIT;
                            n_done  = 1'b0;
                        end
                    end
                    stti_pkg::OP_REMOVE: begin
                        n_idx = row_a;
                        n_c   = '0;
                        if (bad_row) begin
                            n_status = stti_pkg::ST_BAD_INDEX;
                        end else if (row_x + 1'b1 == count_x) begin
                            n_count = r_count - 1'b1;
                        end else begin
                            n_state = S_RM_RD;
                            n_done  = 1'b0;
                        end
                    end
                    stti_pkg::OP_FIND_CUR, stti_pkg::OP_FIND_FROM: begin
                        if (r_count == '0) begin
                            n_status = stti_pkg::ST_NOT_FOUND;
                        end else begin
                            t_raddr = '0;
                            n_state = S_FIND_T0;
                            n_done  = 1'b0;
                        end
                    end
                    stti_pkg::OP_RST_CUR: begin
                        n_cursor = '0;
                    end
                    default: begin
                        n_cursor = r_cursor;
                    end
                endcase
            end
            S_APP_CHK: begin
                if (r_ts <= r_t_rdata) begin
                    n_status = stti_pkg::ST_NOT_LATER;
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                end else begin
                    n_state = S_APP_WR;
                end
            end
            S_APP_WR: begin
                // every column is filled so later reads never hit stale data
                v_we    = 1'b1;
                v_waddr = {cnt_a, r_c};
                t_we    = (r_c == '0);
                t_waddr = cnt_a;
                n_c     = r_c + 1'b1;
                if (r_c == CW'(CS - 1)) begin
                    n_count = r_count + 1'b1;
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end
            end
            S_RD_WAIT: begin
                n_tout  = r_t_rdata;
                n_vout  = r_v_rdata;
                n_state = S_IDLE;
                n_done  = 1'b1;
            end
            S_RM_RD: begin
                t_raddr = RW'(idx_x + 1'b1);
                v_raddr = {RW'(idx_x + 1'b1), r_c};
                n_state = S_RM_WR;
            end
            S_RM_WR: begin
                v_we    = 1'b1;
                v_waddr = {r_idx, r_c};
                v_wdata = r_v_rdata;
                t_we    = (r_c == '0);
                t_waddr = r_idx;
                t_wdata = r_t_rdata;
                n_c     = r_c + 1'b1;
                n_state = S_RM_RD;
                if (r_c == CW'(CS - 1)) begin
                    if (idx_x + 2'd2 == count_x) begin
                        n_count = r_count - 1'b1;
                        n_state = S_IDLE;
                        n_done  = 1'b1;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_FIND_T0: begin
                n_prev  = r_t_rdata;
                t_raddr = RW'(count_x - 1'b1);
                n_state = S_FIND_TN;
            end
            S_FIND_TN: begin
                if (r_ts < r_prev || r_ts > r_t_rdata || count_x < XW'(2)) begin
                    n_status = stti_pkg::ST_NOT_FOUND;
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                end else if (start_x + 1'b1 >= count_x) begin
                    // start past the last interval: go to the restart
                    n_idx    = '0;
                    n_second = 1'b1;
                    t_raddr  = '0;
                    n_state  = S_FIND_PREV;
                end else begin
                    n_idx    = start_a;
                    n_second = 1'b0;
                    t_raddr  = start_a;
                    n_state  = S_FIND_PREV;
                end
            end
            S_FIND_PREV: begin
                n_prev  = r_t_rdata;
                t_raddr = RW'(idx_x + 1'b1);
                n_state = S_FIND_CMP;
            end
            S_FIND_CMP: begin
                if (r_ts >= r_prev && r_ts <= r_t_rdata) begin
                    n_found = 10'(r_idx);
                    if (r_op == stti_pkg::OP_FIND_CUR) begin
                        n_cursor = 10'(r_idx);
                    end
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end else if (idx_x + 2'd2 < count_x) begin
                    n_idx   = r_idx + 1'b1;
                    n_prev  = r_t_rdata;
                    t_raddr = RW'(idx_x + 2'd2);
                end else if (!r_second) begin
                    n_second = 1'b1;
                    n_idx    = '0;
                    t_raddr  = '0;
                    n_state  = S_FIND_PREV;
                end else begin
                    n_status = stti_pkg::ST_NOT_FOUND;
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_done      <= 1'b0;
            r_count     <= '0;
            r_cursor    <= '0;
            r_ncol      <= 5'd1;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_done   <= n_done;
            r_count  <= n_count;
            r_cursor <= n_cursor;
            if (i_cfg_we) begin
                r_ncol <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_c      <= n_c;
        r_prev   <= n_prev;
        r_second <= n_second;
        r_status <= n_status;
        r_found  <= n_found;
        r_tout   <= n_tout;
        r_vout   <= n_vout;
        if (in_acc) begin
            r_op  <= stti_pkg::t_op'(i_operation);
            r_ts  <= i_timestamp;
            r_row <= i_row_index;
            r_col <= i_column;
            r_dv  <= i_data_value;
        end
        if (out_load) begin
            r_o_status <= r_status;
            r_o_found  <= r_found;
            r_o_tout   <= r_tout;
            r_o_vout   <= r_vout;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_o_status;
    assign o_found_row = r_o_found;
    assign o_time_out  = r_o_tout;
    assign o_value_out = r_o_vout;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        XW'(r_count) <= XW'(MAX_ROWS))
        else $error("row count above table size");

    a_append_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APP_WR) |-> (XW'(r_count) < XW'(MAX_ROWS)))
        else $error("append write with full table");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIND_CMP) |-> (idx_x + 1'b1 < count_x))
        else $error("scan index past last interval");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_IDLE))
        else $error("result pending outside idle");
`endif

endmodule

FILE: dv/tb_sorted_time_table_interval_search_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_time_table_interval_search_core
// Drives table operations (append, edit, read, remove, interval finds) with
// random gaps on both channels, predicts every result from a shadow table and
// checks each output transaction field by field, across several column counts.
// ----------------------------------------------------------------------------
module tb_sorted_time_table_interval_search_core;

    localparam int TIME_W    = stti_pkg::TIME_W;
    localparam int NCOL_W    = stti_pkg::NCOL_W;
    localparam int NROWS     = 1024;
    localparam int NCOLS     = 16;
    localparam int LIMIT_CYC = 3000000;

    typedef struct {
        stti_pkg::t_op     op;
        logic [TIME_W-1:0] ts;
        logic [9:0]        row;
        logic [3:0]        col;
        logic [63:0]       dv;
    } t_item;

    typedef struct {
        logic [2:0]        status;
        logic [9:0]        found;
        logic [TIME_W-1:0] tout;
        logic [63:0]       vout;
    } t_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [NCOL_W-1:0] i_cfg_wdata = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [2:0]        i_operation = '0;
    logic [TIME_W-1:0] i_timestamp = '0;
    logic [9:0]        i_row_index = '0;
    logic [3:0]        i_column = '0;
    logic [63:0]       i_data_value = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [2:0]        o_status;
    logic [9:0]        o_found_row;
    logic [TIME_W-1:0] o_time_out;
    logic [63:0]       o_value_out;

    sorted_time_table_interval_search_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_operation(i_operation), .i_timestamp(i_timestamp),
        .i_row_index(i_row_index), .i_column(i_column),
        .i_data_value(i_data_value),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_status(o_status), .o_found_row(o_found_row),
        .o_time_out(o_time_out), .o_value_out(o_value_out)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // shadow table
    logic [TIME_W-1:0] sh_time [NROWS];
    logic [63:0]       sh_val  [NROWS][NCOLS];
    int unsigned       sh_rows;
    int unsigned       sh_cursor;
    logic [4:0]        sh_ncol;

    t_item   pending_items[$];
    t_result expected_results[$];
    int      mismatches = 0;
    int      cyc = 0;
    bit      hold_in = 1'b0;

    function automatic int unsigned cols_active();
        if (sh_ncol == 0) return 1;
        if (sh_ncol > NCOLS) return NCOLS;
        return sh_ncol;
    endfunction

    function automatic int scan_interval(int unsigned lo, logic [TIME_W-1:0] t);
        if (sh_rows < 2) return -1;
        for (int unsigned i = lo; i < sh_rows - 1; i++)
            if (t >= sh_time[i] && t <= sh_time[i+1]) return i;
        return -1;
    endfunction

    function automatic t_result apply_op(t_item it);
        t_result res;
        int      r;
        res = '{stti_pkg::ST_OK, '0, '0, '0};
        case (it.op)
            stti_pkg::OP_CLEAR: sh_rows = 0;
            stti_pkg::OP_APPEND: begin
                if (sh_rows >= NROWS) res.status = stti_pkg::ST_FULL;
                else if (sh_rows > 0 && it.ts <= sh_time[sh_rows-1])
                    res.status = stti_pkg::ST_NOT_LATER;
                else begin
                    sh_time[sh_rows] = it.ts;
                    for (int j = 0; j < NCOLS; j++) sh_val[sh_rows][j] = it.dv;
                    sh_rows++;
                end
            end
            stti_pkg::OP_SET, stti_pkg::OP_READ: begin
                if (it.row >= sh_rows || it.col >= cols_active())
                    res.status = stti_pkg::ST_BAD_INDEX;
                else if (it.op == stti_pkg::OP_SET) sh_val[it.row][it.col] = it.dv;
                else begin
                    res.tout = sh_time[it.row];
                    res.vout = sh_val[it.row][it.col];
                end
            end
            stti_pkg::OP_REMOVE: begin
                if (it.row >= sh_rows) res.status = stti_pkg::ST_BAD_INDEX;
                else begin
                    for (int unsigned i = it.row; i + 1 < sh_rows; i++) begin
                        sh_time[i] = sh_time[i+1];
                        for (int j = 0; j < NCOLS; j++) sh_val[i][j] = sh_val[i+1][j];
                    end
                    sh_rows--;
                end
            end
            stti_pkg::OP_FIND_CUR, stti_pkg::OP_FIND_FROM: begin
                r = -1;
                if (sh_rows > 0 && it.ts >= sh_time[0] && it.ts <= sh_time[sh_rows-1]) begin
                    r = scan_interval(it.op == stti_pkg::OP_FIND_CUR ? sh_cursor : it.row,
                                      it.ts);
                    if (r < 0) r = scan_interval(0, it.ts);
                end
                if (r < 0) res.status = stti_pkg::ST_NOT_FOUND;
                else begin
                    res.found = r[9:0];
                    if (it.op == stti_pkg::OP_FIND_CUR) sh_cursor = r[9:0];
                end
            end
            default: sh_cursor = 0;
        endcase
        return res;
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_item nxt;
        t_item got;
        bit    fire, idle, calm, vld;
        cyc++;
        if (cyc > LIMIT_CYC) begin
            $display("FAIL sorted_time_table_interval_search_core");
            $finish;
        end else if (i_rst_n) begin
            fire = i_in_valid && !o_in_stall;
            if (fire) begin
                got.op  = stti_pkg::t_op'(i_operation);
                got.ts  = i_timestamp;
                got.row = i_row_index;
                got.col = i_column;
                got.dv  = i_data_value;
                expected_results.insert(expected_results.size(), apply_op(got));
            end
            calm = (cyc > 3000 && cyc < 9000);
            idle = !calm && ($urandom_range(99) < 27);
            vld  = i_in_valid && !fire;
            if (!vld && !idle && !hold_in && pending_items.size() > 0) begin
                nxt = pending_items.pop_front();
                i_operation  <= nxt.op;
                i_timestamp  <= nxt.ts;
                i_row_index  <= nxt.row;
                i_column     <= nxt.col;
                i_data_value <= nxt.dv;
                vld = 1'b1;
            end
            i_in_valid <= vld;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_result want;
        bit      calm;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result status=%0d", o_status);
                end else begin
                    want = expected_results.pop_front();
                    if (o_status !== want.status || o_found_row !== want.found ||
                        o_time_out !== want.tout || o_value_out !== want.vout) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp st=%0d row=%0d t=%h v=%h",
                                      " got st=%0d row=%0d t=%h v=%h"},
                                want.status, want.found, want.tout, want.vout,
                                o_status, o_found_row, o_time_out, o_value_out);
                    end
                end
            end
            calm = (cyc > 3000 && cyc < 9000);
            i_out_stall <= !calm && ($urandom_range(99) < 27);
        end
    end

    // generator-side view of the table, to keep sequences well formed
    logic [TIME_W-1:0] gen_times[$];
    logic [TIME_W-1:0] gen_t;
    int unsigned       gen_cols;

    task automatic add_item(stti_pkg::t_op op, logic [TIME_W-1:0] ts, logic [9:0] row,
                            logic [3:0] col, logic [63:0] dv);
        pending_items.insert(pending_items.size(), '{op, ts, row, col, dv});
        case (op)
            stti_pkg::OP_CLEAR: gen_times.delete();
            stti_pkg::OP_APPEND:
                if (gen_times.size() < NROWS &&
                    (gen_times.size() == 0 || ts > gen_times[$]))
                    gen_times.insert(gen_times.size(), ts);
            stti_pkg::OP_REMOVE: if (row < gen_times.size()) gen_times.delete(row);
            default: ;
        endcase
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic add_random();
        int unsigned       n, k, r;
        logic [TIME_W-1:0] ts;
        n = gen_times.size();
        r = $urandom_range(99);
        if (n > 48 && r < 30) r = 80;
        if (r < 30) begin
            if ($urandom_range(9) == 0) ts = (n > 0 && $urandom_range(1)) ? gen_times[$]
                                                                         : rand64();
            else begin
                gen_t += $urandom_range(1, 1 << 20);
                ts = gen_t;
            end
            add_item(stti_pkg::OP_APPEND, ts, $urandom, $urandom, rand64());
        end else if (r < 48) begin
            if (n >= 2 && $urandom_range(9) != 0) begin
                k = $urandom_range(n - 2);
                case ($urandom_range(3))
                    0: ts = gen_times[k];
                    1: ts = gen_times[k+1];
                    default: ts = gen_times[k] + ((gen_times[k+1] - gen_times[k]) *
                                  $urandom_range(100)) / 100;
                endcase
            end else ts = rand64();
            add_item($urandom_range(1) ? stti_pkg::OP_FIND_CUR : stti_pkg::OP_FIND_FROM, ts,
                     $urandom_range(3) ? $urandom_range(n + 2) : $urandom, 0, rand64());
        end else if (r < 75) begin
            add_item(r < 62 ? stti_pkg::OP_SET : stti_pkg::OP_READ, rand64(),
                     (n > 0 && $urandom_range(7)) ? $urandom_range(n - 1) : $urandom,
                     $urandom_range(7) ? $urandom_range(gen_cols - 1) : $urandom,
                     rand64());
        end else if (r < 85) begin
            add_item(stti_pkg::OP_REMOVE, rand64(),
                     (n > 0 && $urandom_range(7)) ? n - 1 - $urandom_range(n > 4 ? 3 : n - 1)
                                                  : $urandom,
                     $urandom, rand64());
        end else if (r < 89) begin
            add_item(stti_pkg::OP_CLEAR, rand64(), $urandom, $urandom, rand64());
        end else if (r < 93) begin
            add_item(stti_pkg::OP_RST_CUR, rand64(), $urandom, $urandom, rand64());
        end else begin
            // noise: any operation code with random fields
            k = $urandom_range(7);
            add_item(stti_pkg::t_op'(k), rand64(), $urandom, $urandom, rand64());
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_ncol(logic [4:0] v);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        sh_ncol = v;
        i_cfg_we <= 1'b0;
        gen_cols = (v == 0) ? 1 : (v > NCOLS ? NCOLS : v);
        @(posedge i_clk);
    endtask

    logic [4:0] settings[6] = '{5'd16, 5'd0, 5'd31, 5'd7, 5'd1, 5'd16};

    initial begin
        sh_rows = 0;
        sh_cursor = 0;
        sh_ncol = 1;
        gen_cols = 1;
        for (int i = 0; i < NROWS; i++) begin
            sh_time[i] = '0;
            for (int j = 0; j < NCOLS; j++) sh_val[i][j] = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, one row, extremes, bad indexes
        add_item(stti_pkg::OP_FIND_CUR, 48'h10, 0, 0, 0);
        add_item(stti_pkg::OP_READ, 0, 0, 0, 0);
        add_item(stti_pkg::OP_REMOVE, 0, 0, 0, 0);
        add_item(stti_pkg::OP_APPEND, 48'h0, 0, 0, 64'h0);
        add_item(stti_pkg::OP_APPEND, 48'h0, 0, 0, 64'h1);
        add_item(stti_pkg::OP_FIND_CUR, 48'h0, 0, 0, 0);
        add_item(stti_pkg::OP_APPEND, 48'h1000000, 0, 0, '1);
        add_item(stti_pkg::OP_APPEND, '1, 0, 0, 64'h5555_AAAA_5555_AAAA);
        add_item(stti_pkg::OP_APPEND, '1, 0, 0, 0);
        add_item(stti_pkg::OP_SET, 0, 1, 0, 64'hDEAD_BEEF_0123_4567);
        add_item(stti_pkg::OP_SET, 0, 1, 1, 64'h1);
        add_item(stti_pkg::OP_READ, 0, 1, 0, 0);
        add_item(stti_pkg::OP_READ, 0, 2, 15, 0);
        add_item(stti_pkg::OP_READ, 0, 1023, 0, 0);
        add_item(stti_pkg::OP_FIND_CUR, 48'h800000, 0, 0, 0);
        add_item(stti_pkg::OP_FIND_CUR, '1, 0, 0, 0);
        add_item(stti_pkg::OP_FIND_FROM, 48'h1000000, 1023, 0, 0);
        add_item(stti_pkg::OP_FIND_FROM, 48'h800000, 1, 0, 0);
        add_item(stti_pkg::OP_FIND_CUR, 48'h0, 0, 0, 0);
        add_item(stti_pkg::OP_RST_CUR, 0, 0, 0, 0);
        add_item(stti_pkg::OP_REMOVE, 0, 1023, 0, 0);
        add_item(stti_pkg::OP_REMOVE, 0, 1, 0, 0);
        add_item(stti_pkg::OP_CLEAR, 0, 0, 0, 0);
        add_item(stti_pkg::OP_FIND_FROM, 48'h0, 0, 0, 0);

        gen_t = {1'b0, $urandom_range(32'h7FFF_0000), 15'h0};
        foreach (settings[s]) begin
            write_ncol(settings[s]);
            for (int i = 0; i < 25; i++) begin
                add_random();
                if (s == 2 && i == 15) begin
                    // let traffic build up, then drain the block completely
                    while (pending_items.size() > 8) @(posedge i_clk);
                    hold_in = 1'b1;
                    while (expected_results.size() > 0 || i_in_valid) @(posedge i_clk);
                    hold_in = 1'b0;
                end
            end
        end

        // full table
        wait_drained();
        add_item(stti_pkg::OP_CLEAR, 0, 0, 0, 0);
        for (int i = 0; i < NROWS; i++) begin
            gen_t += $urandom_range(1, 4096);
            add_item(stti_pkg::OP_APPEND, gen_t, 0, 0, rand64());
        end
        add_item(stti_pkg::OP_APPEND, gen_t + 1, 0, 0, 0);
        add_item(stti_pkg::OP_FIND_CUR, gen_times[700] + 1, 0, 0, 0);
        add_item(stti_pkg::OP_FIND_CUR, gen_times[1023], 0, 0, 0);
        add_item(stti_pkg::OP_FIND_FROM, gen_times[3], 1023, 0, 0);
        add_item(stti_pkg::OP_READ, 0, 1023, 15, 0);
        add_item(stti_pkg::OP_REMOVE, 0, 1023, 0, 0);
        add_item(stti_pkg::OP_CLEAR, 0, 0, 0, 0);

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("PASS sorted_time_table_interval_search_core");
        else
            $display("FAIL sorted_time_table_interval_search_core");
        $finish;
    end

endmodule
